// File: rtl/core/nattcp_pkg.sv
// Package for the NAT TCP connection tracker: field widths, state and
// command codes, flag bit positions and the table entry type.
// No dependencies.
`default_nettype none

package nattcp_pkg;

    localparam int CMD_W            = 2;
    localparam int CONN_INDEX_W     = 8;
    localparam int FLAGS_W          = 8;
    localparam int SEQ_W            = 32;
    localparam int STATE_W          = 4;
    localparam int NUM_CONNECTIONS_DEF = 256;

    localparam int FLAG_FIN_BIT = 0;
    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_RST_BIT = 2;
    localparam int FLAG_ACK_BIT = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_NEW_OUT = 2'd0,
        CMD_NEW_IN  = 2'd1,
        CMD_UPD_OUT = 2'd2,
        CMD_UPD_IN  = 2'd3
    } t_cmd;

    typedef enum logic [STATE_W-1:0] {
        ST_CLOSED        = 4'd0,
        ST_SYN_SENT      = 4'd1,
        ST_SYN_RCVD_PROC = 4'd2,
        ST_SYN_RCVD      = 4'd3,
        ST_ESTAB         = 4'd4,
        ST_FW1           = 4'd5,
        ST_FW2           = 4'd6,
        ST_CLOSING       = 4'd7,
        ST_TIME_WAIT     = 4'd8,
        ST_CLOSE_WAIT    = 4'd9,
        ST_LAST_ACK      = 4'd10
    } t_tcp_state;

    typedef struct packed {
        t_tcp_state       state;
        logic [SEQ_W-1:0] fin_sent;
        logic [SEQ_W-1:0] fin_recv;
    } t_entry;

endpackage

`default_nettype wire

// File: rtl/core/nattcp_table.sv
// Connection table: one synchronous memory of entries with a registered read,
// per-entry valid bits cleared by reset, and forwarding of the last write.
// Depends on nattcp_pkg.
`default_nettype none

module nattcp_table import nattcp_pkg::*; #(
    parameter int DEPTH = NUM_CONNECTIONS_DEF,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    output t_entry             o_rd_data
);

    t_entry             r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    t_entry             r_rd_data;
    logic               r_rd_valid;
    logic [AW-1:0]      r_rd_addr;
    logic               r_lw_valid;
    logic [AW-1:0]      r_lw_addr;
    t_entry             r_lw_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
        if (i_wr_en) begin
            r_lw_addr <= i_wr_addr;
            r_lw_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_lw_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
                r_lw_valid         <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // The last write is either newer than the memory read or equal to it.
    always_comb begin
        if (r_lw_valid && (r_lw_addr == r_rd_addr)) begin
            o_rd_data = r_lw_data;
        end else if (r_rd_valid) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_lw_valid && r_valid[r_lw_addr])
        else $error("written entry not marked valid");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && i_rd_en && (i_wr_addr == i_rd_addr)) |=>
            (o_rd_data == $past(i_wr_data)))
        else $error("write not forwarded to a read of the same entry");
    assert property (@(posedge i_clk)
        !i_rst_n |=> (r_valid == '0) && !r_lw_valid)
        else $error("table not cleared by reset");

endmodule

`default_nettype wire

// File: rtl/core/nattcp_next.sv
// Next-entry logic: applies the TCP transition rules of one segment to a
// table entry and returns the updated entry.
// Depends on nattcp_pkg.
`default_nettype none

module nattcp_next import nattcp_pkg::*; (
    input  wire t_cmd               i_command,
    input  wire logic [FLAGS_W-1:0] i_tcp_flags,
    input  wire logic [SEQ_W-1:0]   i_seq_number,
    input  wire logic [SEQ_W-1:0]   i_ack_number,
    input  wire t_entry             i_entry,
    output t_entry                  o_entry
);

    logic       syn;
    logic       ack;
    logic       fin;
    logic       rst;
    logic       ack_past_fin;
    t_tcp_state cur;

    assign syn          = i_tcp_flags[FLAG_SYN_BIT];
    assign ack          = i_tcp_flags[FLAG_ACK_BIT];
    assign fin          = i_tcp_flags[FLAG_FIN_BIT];
    assign rst          = i_tcp_flags[FLAG_RST_BIT];
    assign ack_past_fin = ack && (i_ack_number > i_entry.fin_sent);
    assign cur          = rst ? ST_CLOSED : i_entry.state;

    always_comb begin
        o_entry = i_entry;
        case (i_command)
            CMD_NEW_OUT, CMD_NEW_IN: begin
                if (syn) begin
                    o_entry.state    = (i_command == CMD_NEW_OUT) ? ST_SYN_SENT
                                                                  : ST_SYN_RCVD_PROC;
                    o_entry.fin_sent = '0;
                    o_entry.fin_recv = '0;
                end else begin
                    o_entry.state = ST_CLOSED;
                end
            end
            CMD_UPD_OUT: begin
                o_entry.state = cur;
                case (cur)
                    ST_CLOSED: begin
                        if (syn) begin
                            o_entry.state    = ack ? ST_SYN_RCVD : ST_SYN_SENT;
                            o_entry.fin_sent = '0;
                            o_entry.fin_recv = '0;
                        end
                    end
                    ST_SYN_RCVD_PROC: begin
                        if (ack && syn) begin
                            o_entry.state = ST_SYN_RCVD;
                        end
                    end
                    ST_SYN_RCVD, ST_ESTAB, ST_CLOSE_WAIT: begin
                        if (fin) begin
                            o_entry.state    = (cur == ST_CLOSE_WAIT) ? ST_LAST_ACK : ST_FW1;
                            o_entry.fin_sent = i_seq_number;
                        end else if (syn) begin
                            o_entry.state    = ST_SYN_SENT;
                            o_entry.fin_sent = '0;
                            o_entry.fin_recv = '0;
                        end
                    end
                    ST_FW1, ST_FW2, ST_CLOSING, ST_TIME_WAIT, ST_LAST_ACK: begin
                        if (syn) begin
                            o_entry.state    = ST_SYN_SENT;
                            o_entry.fin_sent = '0;
                            o_entry.fin_recv = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                o_entry.state = cur;
                case (cur)
                    ST_CLOSED: begin
                        if (syn) begin
                            o_entry.state    = ST_SYN_RCVD_PROC;
                            o_entry.fin_sent = '0;
                            o_entry.fin_recv = '0;
                        end
                    end
                    ST_SYN_SENT: begin
                        if (syn) begin
                            o_entry.state = ack ? ST_ESTAB : ST_SYN_RCVD;
                        end
                    end
                    ST_SYN_RCVD: begin
                        if (ack) begin
                            o_entry.state = ST_ESTAB;
                        end
                    end
                    ST_ESTAB, ST_FW1, ST_FW2: begin
                        if (fin) begin
                            o_entry.state    = (cur == ST_ESTAB) ? ST_CLOSE_WAIT : ST_TIME_WAIT;
                            o_entry.fin_recv = i_seq_number;
                        end else if ((cur == ST_FW1) && ack_past_fin) begin
                            o_entry.state = ST_FW2;
                        end else if (syn) begin
                            o_entry.state    = ST_SYN_RCVD_PROC;
                            o_entry.fin_sent = '0;
                            o_entry.fin_recv = '0;
                        end
                    end
                    ST_LAST_ACK: begin
                        if (ack_past_fin) begin
                            o_entry.state = ST_TIME_WAIT;
                        end else if (syn) begin
                            o_entry.state    = ST_SYN_RCVD_PROC;
                            o_entry.fin_sent = '0;
                            o_entry.fin_recv = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/nat_tcp_connection_tracker.sv
// NAT TCP connection tracker, top level. An accepted beat is taken into the
// stage-1 registers and the table read; its new state goes into the result
// register when stage 1 fires. Throughput: one beat per cycle unless stalled;
// the read-modify-write of the connection table overlaps with the next read
// through forwarding of the last write. Reset: synchronous; per-entry valid
// bits clear at once, so every entry reads as closed with zero FIN sequences.
`default_nettype none

module nat_tcp_connection_tracker import nattcp_pkg::*; #(
    parameter int NUM_CONNECTIONS = NUM_CONNECTIONS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [CMD_W-1:0]        i_command,
    input  wire logic [CONN_INDEX_W-1:0] i_conn_index,
    input  wire logic [FLAGS_W-1:0]      i_tcp_flags,
    input  wire logic [SEQ_W-1:0]        i_seq_number,
    input  wire logic [SEQ_W-1:0]        i_ack_number,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [STATE_W-1:0]           o_new_state,
    output logic                         o_established
);

    localparam int INDEX_SPAN = 2 ** CONN_INDEX_W;
    localparam int DEPTH = (NUM_CONNECTIONS < INDEX_SPAN) ? NUM_CONNECTIONS : INDEX_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                 in_accept;
    logic                 in_range;
    logic                 s1_fire;
    t_entry               rd_entry;
    t_entry               new_entry;

    logic                 r_s1_valid;
    logic                 r_s1_in_range;
    t_cmd                 r_s1_command;
    logic [AW-1:0]        r_s1_addr;
    logic [FLAGS_W-1:0]   r_s1_flags;
    logic [SEQ_W-1:0]     r_s1_seq;
    logic [SEQ_W-1:0]     r_s1_ack;
    logic                 r_out_valid;
    logic [STATE_W-1:0]   r_out_state;
    logic [STATE_W-1:0]   n_out_state;

    assign s1_fire   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !s1_fire;
    assign in_accept = i_valid && !o_stall;
    assign in_range  = 32'(i_conn_index) < NUM_CONNECTIONS;

    nattcp_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept && in_range),
        .i_rd_addr (AW'(i_conn_index)),
        .i_wr_en   (s1_fire && r_s1_in_range),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (new_entry),
        .o_rd_data (rd_entry)
    );

    nattcp_next u_next (
        .i_command    (r_s1_command),
        .i_tcp_flags  (r_s1_flags),
        .i_seq_number (r_s1_seq),
        .i_ack_number (r_s1_ack),
        .i_entry      (rd_entry),
        .o_entry      (new_entry)
    );

    assign n_out_state = r_s1_in_range ? new_entry.state : ST_CLOSED;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_in_range <= in_range;
            r_s1_command  <= t_cmd'(i_command);
            r_s1_addr     <= AW'(i_conn_index);
            r_s1_flags    <= i_tcp_flags;
            r_s1_seq      <= i_seq_number;
            r_s1_ack      <= i_ack_number;
        end
        if (s1_fire) begin
            r_out_state <= n_out_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_new_state   = r_out_state;
    assign o_established = (r_out_state == ST_ESTAB);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_established == (o_new_state == ST_ESTAB)))
        else $error("established flag disagrees with new state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_new_state <= ST_LAST_ACK))
        else $error("result carries an undefined state code");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_new_state)))
        else $error("stalled result beat lost or changed");
    assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !r_s1_valid))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
